[hdl/mrq_pkg.sv]
package mrq_pkg;

  localparam int AGE_W = 10;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam int MAX_RESULTS = 16;

  typedef logic [2:0] status_t;
  localparam status_t ST_INITIAL  = 3'd0;
  localparam status_t ST_SYN      = 3'd1;
  localparam status_t ST_ACK_WAIT = 3'd2;
  localparam status_t ST_APPROVED = 3'd3;
  localparam status_t ST_ACK_REQ  = 3'd4;
  localparam status_t ST_FIN      = 3'd5;

  typedef logic [2:0] action_t;
  localparam action_t ACT_NONE     = 3'd0;
  localparam action_t ACT_NODE_REQ = 3'd1;
  localparam action_t ACT_SEND     = 3'd2;
  localparam action_t ACT_EXFIL    = 3'd3;
  localparam action_t ACT_ACCEPTED = 3'd4;
  localparam action_t ACT_FULL     = 3'd5;
  localparam action_t ACT_NO_MATCH = 3'd6;

  localparam logic [2:0] REQ_ADD  = 3'd0;
  localparam logic [2:0] REQ_TICK = 3'd1;
  localparam logic [2:0] REQ_RACK = 3'd2;
  localparam logic [2:0] REQ_APPR = 3'd3;
  localparam logic [2:0] REQ_MACK = 3'd4;

  localparam logic [1:0] CFG_SYN      = 2'd0;
  localparam logic [1:0] CFG_ACK_WAIT = 2'd1;
  localparam logic [1:0] CFG_ACK_REQ  = 2'd2;
  localparam logic [1:0] CFG_EXFIL    = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_RACK = 2'd1,
    OP_APPR = 2'd2,
    OP_MACK = 2'd3
  } op_t;

  typedef struct packed {
    status_t          status;
    logic [AGE_W-1:0] age;
    logic [7:0]       msg;
  } entry_t;

  typedef struct packed {
    logic [AGE_W-1:0] syn_timeout;
    logic [AGE_W-1:0] ack_wait_timeout;
    logic [AGE_W-1:0] ack_req_timeout;
    logic             exfil_mode;
  } cfg_t;

  typedef struct packed {
    entry_t  word;
    logic    remove;
    logic    emit;
    action_t action;
  } head_t;

endpackage

[hdl/message_retry_queue.sv]
// Message retry queue.
// Items: pulse start with req_type/message_id while busy is low; the item is
// taken at that edge. Configuration: cfg_we, cfg_index, cfg_data, taken on
// any edge while idle (0 syn_timeout, 1 ack_wait_timeout, 2 ack_req_timeout,
// 3 exfil_mode).
// Results: each word is on action/slot/msg_handle/status_timer_reset/last
// for one cycle with result_valid high; last marks the final word of an item.
// Add and unknown items: one word the cycle after start, busy stays low.
// Tick and match items: the queue rotates through a row of entry cells past
// a single head unit, one entry per cycle. The item visits each queued entry,
// then a flush state gives the final word (an empty queue goes straight to it);
// a tick word leaves the cycle after the next acting entry is visited.
// Reset empties the queue and loads the default timeouts. Results cannot be
// held off by the receiver.
module message_retry_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] req_type,
  input  logic [7:0] message_id,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  output logic       result_valid,
  output logic [2:0] action,
  output logic [3:0] slot,
  output logic [7:0] msg_handle,
  output logic       status_timer_reset,
  output logic       last
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  typedef struct packed {
    mrq_pkg::action_t action;
    logic [3:0]       slot;
    logic [7:0]       msg;
  } res_t;

  state_t          state;
  mrq_pkg::cfg_t   cfg;
  mrq_pkg::op_t    op;
  logic [CW-1:0]   cnt, n0, iter, pos;
  logic [4:0]      nres;
  logic            have_pend, found;
  res_t            pend;
  mrq_pkg::entry_t words [QUEUE_DEPTH];
  mrq_pkg::entry_t add_word;
  mrq_pkg::head_t  head;
  logic            add_we, shift;
  logic            accept, can_emit;
  logic [CW-1:0]   cnt_m1;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign add_we = accept && req_type == mrq_pkg::REQ_ADD && cnt != CW'(QUEUE_DEPTH);
  assign shift = (state == S_RUN);
  assign cnt_m1 = cnt - 1'b1;
  assign add_word = '{status: mrq_pkg::ST_INITIAL, age: '0, msg: message_id};
  assign can_emit = head.emit && nres != 5'(mrq_pkg::MAX_RESULTS);

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      mrq_pkg::entry_t nbr;
      if (g == QUEUE_DEPTH - 1) begin : g_end
        assign nbr = '0;
      end else begin : g_mid
        assign nbr = words[g+1];
      end
      mrq_cell #(.IW(IW), .IDX(g)) u_cell (
        .clk      (clk),
        .add_we   (add_we),
        .add_idx  (cnt[IW-1:0]),
        .add_word (add_word),
        .shift    (shift),
        .tail_en  (!head.remove),
        .tail_idx (cnt_m1[IW-1:0]),
        .proc_word(head.word),
        .nbr_word (nbr),
        .word     (words[g])
      );
    end
  endgenerate

  mrq_head u_head (
    .word (words[0]),
    .op   (op),
    .cfg  (cfg),
    .found(found),
    .res  (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.syn_timeout <= 10'd120;
      cfg.ack_wait_timeout <= 10'd600;
      cfg.ack_req_timeout <= 10'd120;
      cfg.exfil_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrq_pkg::CFG_SYN:      cfg.syn_timeout <= cfg_data;
        mrq_pkg::CFG_ACK_WAIT: cfg.ack_wait_timeout <= cfg_data;
        mrq_pkg::CFG_ACK_REQ:  cfg.ack_req_timeout <= cfg_data;
        mrq_pkg::CFG_EXFIL:    cfg.exfil_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      result_valid <= 1'b0;
      have_pend <= 1'b0;
      found <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            status_timer_reset <= 1'b0;
            slot <= '0;
            msg_handle <= '0;
            action <= mrq_pkg::ACT_NONE;
            last <= 1'b1;
            have_pend <= 1'b0;
            found <= 1'b0;
            nres <= '0;
            iter <= '0;
            pos <= '0;
            n0 <= cnt;
            op <= mrq_pkg::OP_TICK;
            case (req_type)
              mrq_pkg::REQ_ADD: begin
                result_valid <= 1'b1;
                msg_handle <= message_id;
                if (cnt == CW'(QUEUE_DEPTH)) begin
                  action <= mrq_pkg::ACT_FULL;
                end else begin
                  action <= mrq_pkg::ACT_ACCEPTED;
                  slot <= 4'(cnt);
                  cnt <= cnt + 1'b1;
                end
              end
              mrq_pkg::REQ_TICK, mrq_pkg::REQ_RACK, mrq_pkg::REQ_APPR,
              mrq_pkg::REQ_MACK: begin
                if (req_type == mrq_pkg::REQ_RACK) op <= mrq_pkg::OP_RACK;
                if (req_type == mrq_pkg::REQ_APPR) op <= mrq_pkg::OP_APPR;
                if (req_type == mrq_pkg::REQ_MACK) op <= mrq_pkg::OP_MACK;
                state <= (cnt == '0) ? S_FLUSH : S_RUN;
              end
              default: begin
                result_valid <= 1'b1;
              end
            endcase
          end
        end
        S_RUN: begin
          iter <= iter + 1'b1;
          if (head.remove) begin
            cnt <= cnt - 1'b1;
          end
          if (op == mrq_pkg::OP_TICK) begin
            if (!head.remove) pos <= pos + 1'b1;
            if (can_emit) begin
              nres <= nres + 1'b1;
              have_pend <= 1'b1;
              pend <= '{action: head.action, slot: 4'(pos), msg: words[0].msg};
              if (have_pend) begin
                result_valid <= 1'b1;
                action <= pend.action;
                slot <= pend.slot;
                msg_handle <= pend.msg;
                status_timer_reset <= (pend.action == mrq_pkg::ACT_SEND);
                last <= 1'b0;
              end
            end
          end else if (head.emit) begin
            found <= 1'b1;
            have_pend <= 1'b1;
            pend <= '{action: mrq_pkg::ACT_NONE, slot: 4'(iter), msg: words[0].msg};
          end
          if (iter == n0 - 1'b1) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          result_valid <= 1'b1;
          last <= 1'b1;
          if (have_pend) begin
            action <= pend.action;
            slot <= pend.slot;
            msg_handle <= pend.msg;
            status_timer_reset <= (pend.action == mrq_pkg::ACT_SEND);
          end else begin
            action <= (op == mrq_pkg::OP_TICK) ? mrq_pkg::ACT_NONE
                                               : mrq_pkg::ACT_NO_MATCH;
            slot <= '0;
            msg_handle <= '0;
            status_timer_reset <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(QUEUE_DEPTH)) else $error("queue count out of range");
  a_run_not_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && result_valid) |-> !last) else $error("last inside rotation");
  a_flush_out: assert property (@(posedge clk) disable iff (rst)
    state == S_FLUSH |=> result_valid && last) else $error("missing final word");
  a_timer: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status_timer_reset) |-> action == mrq_pkg::ACT_SEND)
    else $error("timer restart without send");
`endif

endmodule

[hdl/mrq_cell.sv]
module mrq_cell #(
  parameter int IW = 4,
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            add_we,
  input  logic [IW-1:0]   add_idx,
  input  mrq_pkg::entry_t add_word,
  input  logic            shift,
  input  logic            tail_en,
  input  logic [IW-1:0]   tail_idx,
  input  mrq_pkg::entry_t proc_word,
  input  mrq_pkg::entry_t nbr_word,
  output mrq_pkg::entry_t word
);

  always_ff @(posedge clk) begin
    if (add_we && add_idx == IW'(IDX)) begin
      word <= add_word;
    end else if (shift) begin
      if (tail_en && tail_idx == IW'(IDX)) begin
        word <= proc_word;
      end else begin
        word <= nbr_word;
      end
    end
  end

endmodule

[hdl/mrq_head.sv]
module mrq_head (
  input  mrq_pkg::entry_t word,
  input  mrq_pkg::op_t    op,
  input  mrq_pkg::cfg_t   cfg,
  input  logic            found,
  output mrq_pkg::head_t  res
);

  mrq_pkg::status_t m_a, m_b, m_next;
  logic [mrq_pkg::AGE_W-1:0] age0;

  always_comb begin
    res = '0;
    res.word = word;
    res.action = mrq_pkg::ACT_NONE;
    age0 = word.age;
    m_a = mrq_pkg::ST_SYN;
    m_b = mrq_pkg::ST_SYN;
    m_next = mrq_pkg::ST_ACK_WAIT;
    unique case (op)
      mrq_pkg::OP_TICK: begin
        if (word.status == mrq_pkg::ST_FIN) begin
          res.remove = 1'b1;
        end else begin
          case (word.status)
            mrq_pkg::ST_INITIAL: begin
              age0 = '0;
              res.emit = 1'b1;
              if (cfg.exfil_mode) begin
                res.word.status = mrq_pkg::ST_FIN;
                res.action = mrq_pkg::ACT_EXFIL;
              end else begin
                res.word.status = mrq_pkg::ST_SYN;
                res.action = mrq_pkg::ACT_NODE_REQ;
              end
            end
            mrq_pkg::ST_SYN: begin
              if (word.age > cfg.syn_timeout) begin
                age0 = '0;
                res.emit = 1'b1;
                res.action = mrq_pkg::ACT_NODE_REQ;
              end
            end
            mrq_pkg::ST_ACK_WAIT: begin
              if (word.age > cfg.ack_wait_timeout) begin
                age0 = '0;
                res.emit = 1'b1;
                res.word.status = mrq_pkg::ST_SYN;
                res.action = mrq_pkg::ACT_NODE_REQ;
              end
            end
            mrq_pkg::ST_APPROVED: begin
              res.emit = 1'b1;
              res.word.status = mrq_pkg::ST_ACK_REQ;
              res.action = mrq_pkg::ACT_SEND;
            end
            mrq_pkg::ST_ACK_REQ: begin
              if (word.age > cfg.ack_req_timeout) begin
                age0 = '0;
                res.emit = 1'b1;
                res.word.status = mrq_pkg::ST_SYN;
                res.action = mrq_pkg::ACT_NODE_REQ;
              end
            end
            default: ;
          endcase
          res.word.age = (age0 == mrq_pkg::AGE_MAX) ? age0 : age0 + 1'b1;
        end
      end
      mrq_pkg::OP_RACK, mrq_pkg::OP_APPR, mrq_pkg::OP_MACK: begin
        if (op == mrq_pkg::OP_APPR) begin
          m_b = mrq_pkg::ST_ACK_WAIT;
          m_next = mrq_pkg::ST_APPROVED;
        end else if (op == mrq_pkg::OP_MACK) begin
          m_a = mrq_pkg::ST_ACK_REQ;
          m_b = mrq_pkg::ST_ACK_REQ;
          m_next = mrq_pkg::ST_FIN;
        end
        if (!found && (word.status == m_a || word.status == m_b)) begin
          res.word.status = m_next;
          res.emit = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

[test/testbench.sv]
module testbench;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 24;
  localparam int N_DIR = 19;
  localparam int N_PHASES = 8;

  typedef struct packed {
    mrq_pkg::action_t act;
    logic [3:0]       slot;
    logic [7:0]       handle;
    logic             tmr;
    logic             last;
  } word_t;

  typedef struct packed {
    logic [2:0]       req;
    logic [7:0]       id;
    logic             chk;
    mrq_pkg::action_t act;
    logic [3:0]       slot;
    logic [7:0]       handle;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [2:0]       req_type = '0;
  logic [7:0]       message_id = '0;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [9:0]       cfg_data = '0;
  logic             result_valid;
  mrq_pkg::action_t action;
  logic [3:0]       slot;
  logic [7:0]       msg_handle;
  logic             status_timer_reset;
  logic             last;

  message_retry_queue #(.QUEUE_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .message_id(message_id),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .action(action), .slot(slot),
    .msg_handle(msg_handle), .status_timer_reset(status_timer_reset),
    .last(last)
  );

  always #10 clk = ~clk;

  mrq_pkg::status_t q_status [DEPTH];
  logic [9:0]       q_age    [DEPTH];
  logic [7:0]       q_msg    [DEPTH];
  int               q_count;
  logic [9:0]       syn_to, ack_wait_to, ack_req_to;
  logic             exfil;

  word_t pending_words[$];
  int    errors = 0;
  int    idle_cycles = 0;
  bit    no_gaps = 1'b0;

  function automatic void push_word(mrq_pkg::action_t a, int p, logic [7:0] h, logic t);
    word_t w;
    w.act = a;
    w.slot = p[3:0];
    w.handle = h;
    w.tmr = t;
    w.last = 1'b0;
    pending_words.push_back(w);
  endfunction

  function automatic void match_queue(mrq_pkg::status_t a, mrq_pkg::status_t b,
                                      mrq_pkg::status_t nxt);
    for (int i = 0; i < q_count; i++) begin
      if (q_status[i] == a || q_status[i] == b) begin
        q_status[i] = nxt;
        push_word(mrq_pkg::ACT_NONE, i, q_msg[i], 1'b0);
        return;
      end
    end
    push_word(mrq_pkg::ACT_NO_MATCH, 0, 8'h00, 1'b0);
  endfunction

  function automatic void tick_queue();
    int n;
    int i;
    logic [9:0] age;
    n = 0;
    i = 0;
    while (i < q_count) begin
      age = q_age[i];
      if (q_status[i] == mrq_pkg::ST_FIN) begin
        for (int k = i; k + 1 < q_count; k++) begin
          q_status[k] = q_status[k+1];
          q_age[k] = q_age[k+1];
          q_msg[k] = q_msg[k+1];
        end
        q_count--;
        continue;
      end
      case (q_status[i])
        mrq_pkg::ST_INITIAL: begin
          age = '0;
          if (exfil) begin
            q_status[i] = mrq_pkg::ST_FIN;
            push_word(mrq_pkg::ACT_EXFIL, i, q_msg[i], 1'b0);
          end else begin
            q_status[i] = mrq_pkg::ST_SYN;
            push_word(mrq_pkg::ACT_NODE_REQ, i, q_msg[i], 1'b0);
          end
          n++;
        end
        mrq_pkg::ST_SYN: if (age > syn_to) begin
          age = '0;
          push_word(mrq_pkg::ACT_NODE_REQ, i, q_msg[i], 1'b0);
          n++;
        end
        mrq_pkg::ST_ACK_WAIT: if (age > ack_wait_to) begin
          age = '0;
          q_status[i] = mrq_pkg::ST_SYN;
          push_word(mrq_pkg::ACT_NODE_REQ, i, q_msg[i], 1'b0);
          n++;
        end
        mrq_pkg::ST_APPROVED: begin
          q_status[i] = mrq_pkg::ST_ACK_REQ;
          push_word(mrq_pkg::ACT_SEND, i, q_msg[i], 1'b1);
          n++;
        end
        mrq_pkg::ST_ACK_REQ: if (age > ack_req_to) begin
          age = '0;
          q_status[i] = mrq_pkg::ST_SYN;
          push_word(mrq_pkg::ACT_NODE_REQ, i, q_msg[i], 1'b0);
          n++;
        end
        default: ;
      endcase
      if (age != mrq_pkg::AGE_MAX) age++;
      q_age[i] = age;
      i++;
    end
    if (n == 0) begin
      push_word(mrq_pkg::ACT_NONE, 0, 8'h00, 1'b0);
    end
  endfunction

  function automatic void predict_item(logic [2:0] req, logic [7:0] id);
    word_t w;
    case (req)
      mrq_pkg::REQ_ADD: begin
        if (q_count >= DEPTH) begin
          push_word(mrq_pkg::ACT_FULL, 0, id, 1'b0);
        end else begin
          q_status[q_count] = mrq_pkg::ST_INITIAL;
          q_age[q_count] = '0;
          q_msg[q_count] = id;
          push_word(mrq_pkg::ACT_ACCEPTED, q_count, id, 1'b0);
          q_count++;
        end
      end
      mrq_pkg::REQ_TICK: tick_queue();
      mrq_pkg::REQ_RACK: match_queue(mrq_pkg::ST_SYN, mrq_pkg::ST_SYN, mrq_pkg::ST_ACK_WAIT);
      mrq_pkg::REQ_APPR: match_queue(mrq_pkg::ST_SYN, mrq_pkg::ST_ACK_WAIT,
                                     mrq_pkg::ST_APPROVED);
      mrq_pkg::REQ_MACK: match_queue(mrq_pkg::ST_ACK_REQ, mrq_pkg::ST_ACK_REQ,
                                     mrq_pkg::ST_FIN);
      default: push_word(mrq_pkg::ACT_NONE, 0, 8'h00, 1'b0);
    endcase
    w = pending_words.pop_back();
    w.last = 1'b1;
    pending_words.push_back(w);
  endfunction

  task automatic issue(stim_row_t r);
    int gap;
    word_t w;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0 || busy) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
      while (busy) @(negedge clk);
    end
    start <= 1'b1;
    req_type <= r.req;
    message_id <= r.id;
    predict_item(r.req, r.id);
    if (r.chk) begin
      w = pending_words.pop_back();
      w.act = r.act;
      w.slot = r.slot;
      w.handle = r.handle;
      w.tmr = 1'b0;
      pending_words.push_back(w);
    end
    @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [9:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mrq_pkg::CFG_SYN:      syn_to = val;
      mrq_pkg::CFG_ACK_WAIT: ack_wait_to = val;
      mrq_pkg::CFG_ACK_REQ:  ack_req_to = val;
      default:               exfil = val[0];
    endcase
  endtask

  function automatic stim_row_t rand_item();
    stim_row_t r;
    int p;
    r = '0;
    r.id = 8'($urandom);
    p = $urandom_range(0, 99);
    if (p < 25)      r.req = mrq_pkg::REQ_ADD;
    else if (p < 60) r.req = mrq_pkg::REQ_TICK;
    else if (p < 72) r.req = mrq_pkg::REQ_RACK;
    else if (p < 84) r.req = mrq_pkg::REQ_APPR;
    else if (p < 96) r.req = mrq_pkg::REQ_MACK;
    else             r.req = 3'($urandom_range(5, 7));
    return r;
  endfunction

  always @(posedge clk) begin
    word_t w;
    if (!rst) begin
      if ((start && !busy) || result_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
      if (result_valid) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word act=%0d slot=%0d handle=%0h", $time,
                   action, slot, msg_handle);
          errors++;
        end else begin
          w = pending_words.pop_front();
          if (action !== w.act) begin
            $display("%0t: action exp %0d got %0d", $time, w.act, action);
            errors++;
          end
          if (slot !== w.slot) begin
            $display("%0t: slot exp %0d got %0d", $time, w.slot, slot);
            errors++;
          end
          if (msg_handle !== w.handle) begin
            $display("%0t: msg_handle exp %0h got %0h", $time, w.handle, msg_handle);
            errors++;
          end
          if (status_timer_reset !== w.tmr) begin
            $display("%0t: status_timer_reset exp %0b got %0b", $time, w.tmr,
                     status_timer_reset);
            errors++;
          end
          if (last !== w.last) begin
            $display("%0t: last exp %0b got %0b", $time, w.last, last);
            errors++;
          end
        end
      end
    end
  end

  stim_row_t dir_rows [N_DIR];

  initial begin
    stim_row_t r;
    dir_rows = '{
      '{mrq_pkg::REQ_TICK, 8'h00, 1'b1, mrq_pkg::ACT_NONE,     4'd0, 8'h00},
      '{mrq_pkg::REQ_RACK, 8'h00, 1'b1, mrq_pkg::ACT_NO_MATCH, 4'd0, 8'h00},
      '{mrq_pkg::REQ_APPR, 8'h00, 1'b1, mrq_pkg::ACT_NO_MATCH, 4'd0, 8'h00},
      '{mrq_pkg::REQ_MACK, 8'h00, 1'b1, mrq_pkg::ACT_NO_MATCH, 4'd0, 8'h00},
      '{3'd5,              8'hff, 1'b1, mrq_pkg::ACT_NONE,     4'd0, 8'h00},
      '{3'd7,              8'h00, 1'b1, mrq_pkg::ACT_NONE,     4'd0, 8'h00},
      '{mrq_pkg::REQ_ADD,  8'h00, 1'b1, mrq_pkg::ACT_ACCEPTED, 4'd0, 8'h00},
      '{mrq_pkg::REQ_ADD,  8'hff, 1'b1, mrq_pkg::ACT_ACCEPTED, 4'd1, 8'hff},
      '{mrq_pkg::REQ_ADD,  8'h5a, 1'b1, mrq_pkg::ACT_ACCEPTED, 4'd2, 8'h5a},
      '{mrq_pkg::REQ_TICK, 8'h00, 1'b0, mrq_pkg::ACT_NONE,     4'd0, 8'h00},
      '{mrq_pkg::REQ_RACK, 8'h00, 1'b0, mrq_pkg::ACT_NONE,     4'd0, 8'h00},
      '{mrq_pkg::REQ_APPR, 8'h00, 1'b0, mrq_pkg::ACT_NONE,     4'd0, 8'h00},
      '{mrq_pkg::REQ_APPR, 8'h00, 1'b0, mrq_pkg::ACT_NONE,     4'd0, 8'h00},
      '{mrq_pkg::REQ_TICK, 8'h00, 1'b0, mrq_pkg::ACT_NONE,     4'd0, 8'h00},
      '{mrq_pkg::REQ_MACK, 8'h00, 1'b0, mrq_pkg::ACT_NONE,     4'd0, 8'h00},
      '{mrq_pkg::REQ_MACK, 8'h00, 1'b0, mrq_pkg::ACT_NONE,     4'd0, 8'h00},
      '{mrq_pkg::REQ_TICK, 8'h00, 1'b0, mrq_pkg::ACT_NONE,     4'd0, 8'h00},
      '{mrq_pkg::REQ_RACK, 8'h00, 1'b0, mrq_pkg::ACT_NONE,     4'd0, 8'h00},
      '{mrq_pkg::REQ_TICK, 8'h00, 1'b0, mrq_pkg::ACT_NONE,     4'd0, 8'h00}
    };
    q_count = 0;
    syn_to = 10'd120;
    ack_wait_to = 10'd600;
    ack_req_to = 10'd120;
    exfil = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) issue(dir_rows[i]);
    while (q_count < DEPTH) begin
      r = '0;
      r.req = mrq_pkg::REQ_ADD;
      r.id = 8'($urandom);
      issue(r);
    end
    r = '{mrq_pkg::REQ_ADD, 8'ha5, 1'b1, mrq_pkg::ACT_FULL, 4'd0, 8'ha5};
    issue(r);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph % 4)
        0: begin
          write_cfg(mrq_pkg::CFG_SYN, 10'd0);
          write_cfg(mrq_pkg::CFG_ACK_WAIT, 10'd0);
          write_cfg(mrq_pkg::CFG_ACK_REQ, 10'd0);
          write_cfg(mrq_pkg::CFG_EXFIL, 10'd0);
        end
        1: begin
          write_cfg(mrq_pkg::CFG_SYN, 10'd1023);
          write_cfg(mrq_pkg::CFG_ACK_WAIT, 10'd1023);
          write_cfg(mrq_pkg::CFG_ACK_REQ, 10'd1023);
          write_cfg(mrq_pkg::CFG_EXFIL, 10'd1);
        end
        2: begin
          write_cfg(mrq_pkg::CFG_SYN, 10'($urandom_range(0, 4)));
          write_cfg(mrq_pkg::CFG_ACK_WAIT, 10'($urandom_range(0, 6)));
          write_cfg(mrq_pkg::CFG_ACK_REQ, 10'($urandom_range(0, 4)));
          write_cfg(mrq_pkg::CFG_EXFIL, 10'($urandom_range(0, 1)));
        end
        default: begin
          write_cfg(mrq_pkg::CFG_SYN, 10'($urandom));
          write_cfg(mrq_pkg::CFG_ACK_WAIT, 10'($urandom));
          write_cfg(mrq_pkg::CFG_ACK_REQ, 10'($urandom));
          write_cfg(mrq_pkg::CFG_EXFIL, 10'd0);
        end
      endcase
      no_gaps = (ph % 3 == 1);
      repeat (15) issue(rand_item());
      drain();
    end

    if (errors == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
